### rtl/assert_macros.svh
// assertion macros shared by the rtl files
// expects i_clk and i_rst_n in the including module; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on i_clk, disabled while i_rst_n is low
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication on i_clk, disabled while i_rst_n is low
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/deq_pkg.sv
// shared types for the double-ended queue: operation and status codes,
// controller states and the command/status structs between control and datapath
package deq_pkg;

    // operation codes carried in the mode field
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ_FRONT = 3'd4,
        OP_READ_BACK  = 3'd5,
        OP_CLEAR      = 3'd6
    } t_mode;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_RDATA = 2'd2
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;    // latch the incoming operation
        logic execute;    // apply the operation to pointers, count and store
        logic load_read;  // move registered store data into the result
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic needs_read; // latched operation returns a stored word
    } t_dp_status;

endpackage

### rtl/deq_dp.sv
// datapath of the double-ended queue: operation latch, ring pointers,
// word count, word store and result payload registers; uses deq_pkg
module deq_dp #(
    parameter int QUEUE_DEPTH = 1024,
    parameter int PTR_W       = $clog2(QUEUE_DEPTH),
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  deq_pkg::t_dp_cmd    i_cmd,
    output deq_pkg::t_dp_status o_status_dp,
    input  logic [2:0]          i_mode,
    input  logic signed [31:0]  i_push_value,
    output logic signed [31:0]  o_read_value,
    output logic [1:0]          o_status,
    output logic [CNT_W-1:0]    o_occupancy
);
    import deq_pkg::*;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    t_mode               r_op_mode;
    logic signed [31:0]  r_op_value;
    logic [PTR_W-1:0]    r_head;
    logic [PTR_W-1:0]    r_tail;
    logic [CNT_W-1:0]    r_count;
    logic [PTR_W-1:0]    n_head;
    logic [PTR_W-1:0]    n_tail;
    logic [CNT_W-1:0]    n_count;
    logic [31:0]         r_rd_data;
    logic signed [31:0]  r_out_value;
    t_status             r_out_status;
    logic [CNT_W-1:0]    r_out_occ;
    logic [31:0]         mem [QUEUE_DEPTH];

    logic [PTR_W-1:0]    head_prev;
    logic [PTR_W-1:0]    head_next;
    logic [PTR_W-1:0]    tail_prev;
    logic [PTR_W-1:0]    tail_next;
    logic                is_full;
    logic                no_words;
    t_status             res_status;
    logic                mem_we;
    logic                rd_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [PTR_W-1:0]    rd_addr;

    // ring neighbors of both pointers
    assign head_prev = (r_head == '0) ? LAST_SLOT : r_head - PTR_W'(1);
    assign head_next = (r_head == LAST_SLOT) ? '0 : r_head + PTR_W'(1);
    assign tail_prev = (r_tail == '0) ? LAST_SLOT : r_tail - PTR_W'(1);
    assign tail_next = (r_tail == LAST_SLOT) ? '0 : r_tail + PTR_W'(1);
    assign is_full   = (r_count == FULL_CNT);
    assign no_words  = (r_count == '0);

    // operation decode: next pointers, count, store access and status
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        res_status = ST_OK;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = r_tail;
        rd_addr    = r_head;
        case (r_op_mode)
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    res_status = ST_FULL;
                end else begin
                    n_head  = head_prev;
                    wr_addr = head_prev;
                    mem_we  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (is_full) begin
                    res_status = ST_FULL;
                end else begin
                    n_tail  = tail_next;
                    wr_addr = r_tail;
                    mem_we  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (no_words) begin
                    res_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                    n_head  = head_next;
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (no_words) begin
                    res_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = tail_prev;
                    n_tail  = tail_prev;
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_READ_FRONT: begin
                if (no_words) begin
                    res_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                end
            end
            OP_READ_BACK: begin
                if (no_words) begin
                    res_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = tail_prev;
                end
            end
            OP_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    assign o_status_dp.needs_read = rd_en;

    // operation latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op_mode  <= t_mode'(i_mode);
            r_op_value <= i_push_value;
        end
    end

    // ring pointers and word count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // word store write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && mem_we) begin
            mem[wr_addr] <= r_op_value;
        end
    end

    // word store read port, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_out_value  <= '0;
            r_out_status <= res_status;
            r_out_occ    <= n_count;
        end else if (i_cmd.load_read) begin
            r_out_value  <= r_rd_data;
        end
    end

    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;
    assign o_occupancy  = r_out_occ;

endmodule

### rtl/deq_ctrl.sv
// controller of the double-ended queue: state machine sequencing each
// operation and the result valid flag; uses deq_pkg
module deq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  deq_pkg::t_dp_status i_status_dp,
    output deq_pkg::t_dp_cmd    o_cmd
);
    import deq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // result slot is free when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = i_status_dp.needs_read ? S_RDATA : S_IDLE;
                end
            end
            S_RDATA: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // commands and handshake outputs
    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                // input held off while reset is low
                o_in_stall    = !i_rst_n;
                o_cmd.capture = i_in_valid && i_rst_n;
            end
            S_EXEC: begin
                o_cmd.execute = out_free;
                if (out_free && !i_status_dp.needs_read) begin
                    n_out_valid = 1'b1;
                end
            end
            S_RDATA: begin
                o_cmd.load_read = 1'b1;
                n_out_valid     = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // state and result valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit words in a ring store of QUEUE_DEPTH
// entries. Each operation beat (push front/back, pop front/back, read
// front/back, clear) gives one result beat with the word read or removed,
// a status (ok, empty, full) and the occupancy after the operation. One
// operation is in flight at a time. An accepted operation beat is latched
// and then executed in S_EXEC once the result register is free; a push,
// clear or error result is valid after that step. A successful pop or
// read then passes through S_RDATA, as the store read data is registered
// before it reaches the result register. A new operation beat is taken
// only in S_IDLE. The result register holds a finished beat while the next
// operation beat is accepted; that operation then waits until the result
// is taken. The input is stalled while reset is low. The store needs no
// clearing pass after reset; only entries written by a push are ever read.
// Depends on deq_pkg, deq_ctrl, deq_dp and assert_macros.svh.
`include "assert_macros.svh"

module double_ended_queue #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [2:0]                          i_mode,
    input  logic signed [31:0]                  i_push_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [31:0]                  o_read_value,
    output logic [1:0]                          o_status,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0]  o_occupancy
);
    import deq_pkg::*;

    localparam int               CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencing
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status_dp (dp_status),
        .o_cmd       (dp_cmd)
    );

    // pointers, count, store and result payload
    deq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status_dp  (dp_status),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

    // an accepted operation blocks the input on the next cycle
    `ASSERT_NEXT(a_accept_then_busy, i_in_valid && !o_in_stall, o_in_stall)
    // error results carry no word
    `ASSERT_IMPL(a_error_zero_word, o_out_valid && (o_status != ST_OK), o_read_value == '0)
    // full only reported at full occupancy
    `ASSERT_IMPL(a_full_count, o_out_valid && (o_status == ST_FULL), o_occupancy == FULL_CNT)
    // empty only reported at zero occupancy
    `ASSERT_IMPL(a_empty_count, o_out_valid && (o_status == ST_EMPTY), o_occupancy == '0)

endmodule
